FILE: design/tes_pkg.sv
// Shared types and constants for the timed event scheduler.
// No dependencies; imported by every other file of the block.
package tes_pkg;

  localparam int TIME_W          = 32;
  localparam int EV_W            = 2;
  localparam int EVENT_SLOTS_DEF = 4;

  // Largest positive signed difference; a scan never selects a slot this far out.
  localparam logic [TIME_W-1:0] DIFF_NONE = 32'h7fff_ffff;

  localparam logic OP_SCHEDULE = 1'b0;
  localparam logic OP_RUN      = 1'b1;

  typedef struct packed {
    logic                     operation;
    logic [EV_W-1:0]          event_index;
    logic [TIME_W-1:0]        reference_time;
    logic signed [TIME_W-1:0] delay;
  } tes_in_req_t;

  typedef struct packed {
    logic              fired_valid;
    logic [EV_W-1:0]   fired_event;
    logic [TIME_W-1:0] fired_time;
    logic [TIME_W-1:0] next_due_time;
    logic              last;
  } tes_out_req_t;

  // controller -> datapath
  typedef struct packed {
    logic capture;     // latch input request
    logic sched_upd;   // write slot and lower next deadline
    logic scan_init;   // restart the slot scan
    logic scan_step;   // evaluate one slot
    logic pass_end;    // commit next deadline from scan
    logic load_out;    // load output register
    logic load_fire;   // output is a fired event (else closing result)
    logic clear_best;  // clear the selected slot
  } tes_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic op_run;
    logic scan_last;
    logic fire_due;
    logic out_free;
  } tes_sts_t;

endpackage

FILE: design/tes_ctrl.sv
// Controller state machine of the timed event scheduler.
// Depends on tes_pkg; drives tes_dp through command and status structs.
module tes_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  tes_pkg::tes_sts_t sts,
  output tes_pkg::tes_cmd_t cmd
);
  import tes_pkg::*;

  localparam logic [2:0] ST_IDLE     = 3'd0;
  localparam logic [2:0] ST_SCHED    = 3'd1;
  localparam logic [2:0] ST_CLOSE    = 3'd2;
  localparam logic [2:0] ST_SCAN     = 3'd3;
  localparam logic [2:0] ST_SCAN_END = 3'd4;
  localparam logic [2:0] ST_FIRE     = 3'd5;

  logic [2:0] state_r, state_nxt;

  assign in_ready = (state_r == ST_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.capture   = 1'b1;
          cmd.scan_init = 1'b1;
          state_nxt     = ST_SCHED;
        end
      end
      ST_SCHED: begin
        // operation is known only once latched
        if (sts.op_run) begin
          state_nxt = ST_SCAN;
        end else begin
          cmd.sched_upd = 1'b1;
          state_nxt     = ST_CLOSE;
        end
      end
      ST_SCAN: begin
        cmd.scan_step = 1'b1;
        if (sts.scan_last) state_nxt = ST_SCAN_END;
      end
      ST_SCAN_END: begin
        cmd.pass_end = 1'b1;
        state_nxt    = sts.fire_due ? ST_FIRE : ST_CLOSE;
      end
      ST_FIRE: begin
        if (sts.out_free) begin
          cmd.load_out   = 1'b1;
          cmd.load_fire  = 1'b1;
          cmd.clear_best = 1'b1;
          cmd.scan_init  = 1'b1;
          state_nxt      = ST_SCAN;
        end
      end
      ST_CLOSE: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

FILE: design/tes_dp.sv
// Datapath of the timed event scheduler: slot table, scan unit, next-due
// register and output register. Depends on tes_pkg; controlled by tes_ctrl.
module tes_dp #(
  parameter int EVENT_SLOTS = tes_pkg::EVENT_SLOTS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  tes_pkg::tes_in_req_t in_req,
  input  logic                 out_ready,
  output logic                 out_valid,
  output tes_pkg::tes_out_req_t out_req,
  input  tes_pkg::tes_cmd_t    cmd,
  output tes_pkg::tes_sts_t    sts
);
  import tes_pkg::*;

  localparam int IDX_W = (EVENT_SLOTS > 1) ? $clog2(EVENT_SLOTS) : 1;

  logic [TIME_W-1:0] slot_r   [EVENT_SLOTS];
  logic [TIME_W-1:0] slot_nxt [EVENT_SLOTS];

  logic              op_r;
  logic [EV_W-1:0]   idx_r;
  logic [TIME_W-1:0] ref_r;
  logic [TIME_W-1:0] when_r;

  logic [IDX_W-1:0]  cnt_r, cnt_nxt;
  logic [TIME_W-1:0] best_diff_r, best_diff_nxt;
  logic [TIME_W-1:0] best_time_r, best_time_nxt;
  logic [IDX_W-1:0]  best_idx_r, best_idx_nxt;
  logic [TIME_W-1:0] pos_diff_r, pos_diff_nxt;
  logic [TIME_W-1:0] pos_time_r, pos_time_nxt;

  logic [TIME_W-1:0] next_r, next_nxt;

  tes_out_req_t      out_r, out_nxt;
  logic              out_valid_r, out_valid_nxt;

  logic [TIME_W-1:0] scan_dl, scan_diff;
  logic              scan_act, scan_pos;
  logic [TIME_W-1:0] sched_dl, next_gap;
  logic              sched_hit, earlier;
  logic [TIME_W-1:0] best_idx_ext;

  // scan: one slot per cycle
  assign scan_dl   = slot_r[cnt_r];
  assign scan_diff = scan_dl - ref_r;
  assign scan_act  = (scan_dl != '0);
  assign scan_pos  = !scan_diff[TIME_W-1] && (scan_diff != '0);

  // schedule: odd deadline, signed-wrap earlier test
  assign sched_dl  = when_r | TIME_W'(1);
  assign sched_hit = (TIME_W'(idx_r) < TIME_W'(EVENT_SLOTS));
  assign next_gap  = next_r - sched_dl;
  assign earlier   = (next_r == '0) || (!next_gap[TIME_W-1] && (next_gap != '0));

  assign best_idx_ext = TIME_W'(best_idx_r);

  always_comb begin
    for (int i = 0; i < EVENT_SLOTS; i++) begin
      slot_nxt[i] = slot_r[i];
      if (cmd.sched_upd && sched_hit && (TIME_W'(idx_r) == TIME_W'(i))) begin
        slot_nxt[i] = (when_r == '0) ? '0 : sched_dl;
      end
      if (cmd.clear_best && (best_idx_r == IDX_W'(i))) begin
        slot_nxt[i] = '0;
      end
    end
  end

  always_comb begin
    cnt_nxt       = cnt_r;
    best_diff_nxt = best_diff_r;
    best_time_nxt = best_time_r;
    best_idx_nxt  = best_idx_r;
    pos_diff_nxt  = pos_diff_r;
    pos_time_nxt  = pos_time_r;
    if (cmd.scan_init) begin
      cnt_nxt       = '0;
      best_diff_nxt = DIFF_NONE;
      best_time_nxt = '0;
      best_idx_nxt  = '0;
      pos_diff_nxt  = DIFF_NONE;
      pos_time_nxt  = '0;
    end else if (cmd.scan_step) begin
      cnt_nxt = cnt_r + IDX_W'(1);
      // strict less: lowest index wins ties
      if (scan_act && ($signed(scan_diff) < $signed(best_diff_r))) begin
        best_diff_nxt = scan_diff;
        best_time_nxt = scan_dl;
        best_idx_nxt  = cnt_r;
      end
      if (scan_act && scan_pos && ($signed(scan_diff) < $signed(pos_diff_r))) begin
        pos_diff_nxt = scan_diff;
        pos_time_nxt = scan_dl;
      end
    end
  end

  always_comb begin
    next_nxt = next_r;
    if (cmd.sched_upd && sched_hit && (when_r != '0) && earlier) begin
      next_nxt = sched_dl;
    end else if (cmd.pass_end) begin
      // fired slots are never positive, so this is stable across passes
      next_nxt = (pos_diff_r != DIFF_NONE) ? pos_time_r : '0;
    end
  end

  always_comb begin
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r;
    if (cmd.load_out) begin
      out_nxt.fired_valid   = cmd.load_fire;
      out_nxt.fired_event   = cmd.load_fire ? best_idx_ext[EV_W-1:0] : '0;
      out_nxt.fired_time    = cmd.load_fire ? best_time_r : '0;
      out_nxt.next_due_time = next_r;
      out_nxt.last          = !cmd.load_fire;
      out_valid_nxt         = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < EVENT_SLOTS; i++) begin
        slot_r[i] <= '0;
      end
      next_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      for (int i = 0; i < EVENT_SLOTS; i++) begin
        slot_r[i] <= slot_nxt[i];
      end
      next_r      <= next_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r   <= in_req.operation;
      idx_r  <= in_req.event_index;
      ref_r  <= in_req.reference_time;
      when_r <= in_req.reference_time + $unsigned(in_req.delay);
    end
    cnt_r       <= cnt_nxt;
    best_diff_r <= best_diff_nxt;
    best_time_r <= best_time_nxt;
    best_idx_r  <= best_idx_nxt;
    pos_diff_r  <= pos_diff_nxt;
    pos_time_r  <= pos_time_nxt;
    out_r       <= out_nxt;
  end

  assign sts.op_run    = (op_r == OP_RUN);
  assign sts.scan_last = (cnt_r == IDX_W'(EVENT_SLOTS - 1));
  assign sts.fire_due  = best_diff_r[TIME_W-1] || (best_diff_r == '0);
  assign sts.out_free  = !out_valid_r || out_ready;

  assign out_valid = out_valid_r;
  assign out_req   = out_r;

endmodule

FILE: design/timed_event_scheduler.sv
// Timed event scheduler: EVENT_SLOTS deadlines on a wrapping 32-bit cycle
// clock. Schedule requests (operation 0) store reference_time + delay with
// bit 0 forced high, or cancel the slot when the sum is zero; a slot
// index >= EVENT_SLOTS changes nothing. Each schedule returns one result with
// last set. Run requests (operation 1) fire every active slot whose signed
// difference to reference_time is at most zero, earliest first and lowest
// index on ties, one result each, then a closing result with last set; all
// results of a run carry the final next-due deadline (zero when none).
// One request at a time. A schedule goes from acceptance through the update
// state to the load of its result. A run walks the slot table in passes,
// one entry per cycle through a single subtract-and-compare unit; each pass
// ends by committing the next deadline, and each fired event loads a result
// and restarts a pass. A new request is accepted while the last result
// still waits in the output register; out_ready low stalls only result loads.
// Depends on tes_pkg, tes_ctrl and tes_dp.
module timed_event_scheduler #(
  parameter int EVENT_SLOTS = tes_pkg::EVENT_SLOTS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  tes_pkg::tes_in_req_t  in_req,
  output logic                  out_valid,
  input  logic                  out_ready,
  output tes_pkg::tes_out_req_t out_req
);
  import tes_pkg::*;

  tes_cmd_t cmd;  // controller commands
  tes_sts_t sts;  // datapath status

  // Sequencer: accept, schedule update or scan passes, result loads.
  tes_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Slot table, scan unit, next-due register and output register.
  tes_dp #(
    .EVENT_SLOTS (EVENT_SLOTS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_req    (in_req),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_req   (out_req),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule

FILE: design/tes_checker.sv
// Port-level checks for timed_event_scheduler, attached by bind.
// Depends on tes_pkg.
module tes_checker (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  out_valid,
  input logic                  out_ready,
  input tes_pkg::tes_out_req_t out_req
);
  import tes_pkg::*;

  // a pending result holds until taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_req))
    else $error("result dropped or changed while stalled");

  // no result right after reset
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // fired results never close a request; closing results never fire
  a_last_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_req.fired_valid != out_req.last))
    else $error("fired_valid and last inconsistent");

  // closing result carries no event
  a_close_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_req.last |-> (out_req.fired_event == '0) && (out_req.fired_time == '0))
    else $error("closing result carries event data");

  // stored deadlines are always odd
  a_fire_odd: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_req.fired_valid |-> out_req.fired_time[0])
    else $error("fired deadline is even");

endmodule

bind timed_event_scheduler tes_checker u_tes_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_req   (out_req)
);
